FILE: src/sae_pkg.sv
// Shared constants, codes and types of the sorted array engine.
package sae_pkg;

  localparam int CAPACITY   = 64;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int VALUE_W    = 32;
  localparam int FUNC_W     = 2;
  localparam int POS_W      = 7;
  localparam int STATUS_W   = 2;
  localparam int CMP_W      = (CNT_W > POS_W) ? CNT_W : POS_W;

  // The reduction tree splits the flag vector into groups of eight.
  localparam int GRP_SIZE   = 8;
  localparam int GRP_IDX_W  = $clog2(GRP_SIZE);
  localparam int GRP_CNT_W  = $clog2(GRP_SIZE + 1);
  localparam int NUM_GRP    = (CAPACITY + GRP_SIZE - 1) / GRP_SIZE;
  localparam int VEC_W      = NUM_GRP * GRP_SIZE;

  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_FIND   = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BAD_INDEX = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd3;

  // Broadcast from the controller to every cell of the chain.
  typedef struct packed {
    logic                      upd_ins;
    logic                      upd_rem;
    logic                      find_sel;
    logic signed [VALUE_W-1:0] value;
    logic [POS_W-1:0]          pos;
    logic [CNT_W-1:0]          count;
  } cell_ctrl_t;

  // Load strobes of the two reduction stages.
  typedef struct packed {
    logic load_vec;
    logic load_grp;
  } red_ctrl_t;

endpackage

FILE: src/sae_if.sv
// Handshake channels of the sorted array engine: request and response.
interface sae_in_if import sae_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic [FUNC_W-1:0]         func;
  logic signed [VALUE_W-1:0] value;
  logic [POS_W-1:0]          position;

  modport source (output valid, func, value, position, input ready);
  modport sink   (input valid, func, value, position, output ready);
endinterface

interface sae_out_if import sae_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic [STATUS_W-1:0]       status;
  logic [IDX_W-1:0]          found_index;
  logic [CNT_W-1:0]          match_count;
  logic signed [VALUE_W-1:0] removed_value;
  logic [CNT_W-1:0]          entry_count;

  modport source (output valid, status, found_index, match_count, removed_value,
                  entry_count, input ready);
  modport sink   (input valid, status, found_index, match_count, removed_value,
                  entry_count, output ready);
endinterface

FILE: src/sae_cell.sv
// One storage cell of the sorted chain: holds an entry and shifts with its neighbors.
module sae_cell import sae_pkg::*; (
  input  logic                      clk_i,
  input  cell_ctrl_t                ctrl_i,
  input  logic [IDX_W-1:0]          idx_i,
  input  logic signed [VALUE_W-1:0] lower_i,
  input  logic signed [VALUE_W-1:0] upper_i,
  input  logic                      gt_prev_i,
  output logic signed [VALUE_W-1:0] entry_o,
  output logic                      gt_o,
  output logic                      vec_o
);

  logic signed [VALUE_W-1:0] entry_q, entry_d;
  logic                      occupied;
  logic                      at_or_above_pos;

  assign occupied        = CMP_W'(idx_i) < CMP_W'(ctrl_i.count);
  assign at_or_above_pos = CMP_W'(idx_i) >= CMP_W'(ctrl_i.pos);

  // Empty cells count as larger than any value, so the first cell that
  // reports greater is the insertion slot.
  assign gt_o = !occupied || (entry_q > ctrl_i.value);

  assign vec_o = ctrl_i.find_sel ?
                 (occupied && at_or_above_pos && (entry_q == ctrl_i.value)) :
                 (occupied && !gt_o);

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.upd_ins && gt_o) begin
      entry_d = gt_prev_i ? lower_i : ctrl_i.value;
    end else if (ctrl_i.upd_rem && at_or_above_pos) begin
      entry_d = upper_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

FILE: src/sae_reduce.sv
// Two-stage registered tree that counts the set flags and finds the lowest one.
module sae_reduce import sae_pkg::*; (
  input  logic                 clk_i,
  input  red_ctrl_t            ctrl_i,
  input  logic [CAPACITY-1:0]  vec_i,
  output logic [CNT_W-1:0]     total_o,
  output logic [IDX_W-1:0]     first_o,
  output logic                 any_o
);

  logic [VEC_W-1:0]     vec_q;
  logic [GRP_CNT_W-1:0] grp_cnt_q   [NUM_GRP];
  logic [GRP_IDX_W-1:0] grp_first_q [NUM_GRP];
  logic                 grp_any_q   [NUM_GRP];

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_vec) begin
      vec_q <= VEC_W'(vec_i);
    end
  end

  for (genvar g = 0; g < NUM_GRP; g++) begin : g_grp
    logic [GRP_SIZE-1:0]  bits;
    logic [GRP_CNT_W-1:0] cnt;
    logic [GRP_IDX_W-1:0] first;

    assign bits = vec_q[g*GRP_SIZE +: GRP_SIZE];

    always_comb begin
      cnt   = '0;
      first = '0;
      for (int b = GRP_SIZE - 1; b >= 0; b--) begin
        cnt = cnt + GRP_CNT_W'(bits[b]);
        if (bits[b]) begin
          first = GRP_IDX_W'(b);
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctrl_i.load_grp) begin
        grp_cnt_q[g]   <= cnt;
        grp_first_q[g] <= first;
        grp_any_q[g]   <= |bits;
      end
    end
  end

  always_comb begin
    total_o = '0;
    first_o = '0;
    any_o   = 1'b0;
    for (int g = NUM_GRP - 1; g >= 0; g--) begin
      total_o = total_o + CNT_W'(grp_cnt_q[g]);
      if (grp_any_q[g]) begin
        first_o = IDX_W'(g * GRP_SIZE) + IDX_W'(grp_first_q[g]);
        any_o   = 1'b1;
      end
    end
  end

endmodule

FILE: src/sorted_array_engine_top.sv
// Top level of the sorted array engine: a chain of entry cells, a reduction tree and control.
// A request beat passes the cell update, group and finish steps in turn; the finish step waits
// until the output register is free. One item is in work at a time: the accept step, the cell
// update and the two registered stages of the count and first-match tree run before the next.
// A new request is taken while the previous result still waits in the output register.
// Reset clears the entry count and the control state; the entry storage is not cleared.
module sorted_array_engine_top import sae_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  sae_in_if.sink    in_i,
  sae_out_if.source out_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CELL,
    ST_GROUP,
    ST_FINISH
  } state_e;

  state_e                    state_q;
  logic [FUNC_W-1:0]         func_q;
  logic signed [VALUE_W-1:0] value_q;
  logic [POS_W-1:0]          pos_q;
  logic [CNT_W-1:0]          count_q;
  logic [STATUS_W-1:0]       pre_status_q;
  logic signed [VALUE_W-1:0] removed_q;

  logic                      out_valid_q;
  logic [STATUS_W-1:0]       out_status_q;
  logic [IDX_W-1:0]          out_found_q;
  logic [CNT_W-1:0]          out_match_q;
  logic signed [VALUE_W-1:0] out_removed_q;
  logic [CNT_W-1:0]          out_count_q;

  cell_ctrl_t                cell_ctrl;
  red_ctrl_t                 red_ctrl;
  logic signed [VALUE_W-1:0] entry_w [CAPACITY];
  logic [CAPACITY-1:0]       gt_w;
  logic [CAPACITY-1:0]       vec_w;
  logic                      full;
  logic                      bad_index;
  logic                      in_fire;
  logic                      out_load;

  logic [CNT_W-1:0]          total;
  logic [IDX_W-1:0]          first;
  logic                      any;

  logic [STATUS_W-1:0]       res_status;
  logic [IDX_W-1:0]          res_found;
  logic [CNT_W-1:0]          res_match;
  logic signed [VALUE_W-1:0] res_removed;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_load   = (state_q == ST_FINISH) && (!out_valid_q || out_o.ready);

  assign full      = count_q >= CNT_W'(CAPACITY);
  assign bad_index = CMP_W'(pos_q) >= CMP_W'(count_q);

  // The cells only change state during the single update cycle; the rest of
  // the time they just present their flags against the held request.
  always_comb begin
    cell_ctrl.upd_ins  = (state_q == ST_CELL) && (func_q == FUNC_INSERT) && !full;
    cell_ctrl.upd_rem  = (state_q == ST_CELL) && (func_q == FUNC_REMOVE) && !bad_index;
    cell_ctrl.find_sel = (func_q == FUNC_FIND);
    cell_ctrl.value    = value_q;
    cell_ctrl.pos      = pos_q;
    cell_ctrl.count    = count_q;
  end

  // Each cell takes its lower neighbor on an insert shift and its upper
  // neighbor when a removal closes the gap.
  for (genvar c = 0; c < CAPACITY; c++) begin : g_cell
    logic signed [VALUE_W-1:0] lower;
    logic signed [VALUE_W-1:0] upper;
    logic                      gt_prev;

    if (c == 0) begin : g_first
      assign lower   = value_q;
      assign gt_prev = 1'b0;
    end else begin : g_mid
      assign lower   = entry_w[c-1];
      assign gt_prev = gt_w[c-1];
    end

    if (c == CAPACITY - 1) begin : g_last
      assign upper = entry_w[c];
    end else begin : g_body
      assign upper = entry_w[c+1];
    end

    sae_cell u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (cell_ctrl),
      .idx_i     (IDX_W'(c)),
      .lower_i   (lower),
      .upper_i   (upper),
      .gt_prev_i (gt_prev),
      .entry_o   (entry_w[c]),
      .gt_o      (gt_w[c]),
      .vec_o     (vec_w[c])
    );
  end

  // For an insert the flags mark entries not greater than the value, so
  // their count is the insertion index. For a find they mark the matches.
  assign red_ctrl.load_vec = (state_q == ST_CELL);
  assign red_ctrl.load_grp = (state_q == ST_GROUP);

  sae_reduce u_reduce (
    .clk_i   (clk_i),
    .ctrl_i  (red_ctrl),
    .vec_i   (vec_w),
    .total_o (total),
    .first_o (first),
    .any_o   (any)
  );

  // Assemble the response from the held request and the tree outputs.
  always_comb begin
    res_status  = STATUS_OK;
    res_found   = '0;
    res_match   = '0;
    res_removed = '0;
    case (func_q)
      FUNC_INSERT: begin
        res_status = pre_status_q;
        if (pre_status_q == STATUS_OK) begin
          res_found = total[IDX_W-1:0];
        end
      end
      FUNC_REMOVE: begin
        res_status = pre_status_q;
        if (pre_status_q == STATUS_OK) begin
          res_found   = pos_q[IDX_W-1:0];
          res_removed = removed_q;
        end
      end
      FUNC_FIND: begin
        if (any) begin
          res_found = first;
          res_match = total;
        end else begin
          res_status = STATUS_NOT_FOUND;
        end
      end
      default: begin
        res_status = STATUS_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      func_q        <= '0;
      value_q       <= '0;
      pos_q         <= '0;
      count_q       <= '0;
      pre_status_q  <= STATUS_OK;
      removed_q     <= '0;
      out_valid_q   <= 1'b0;
      out_status_q  <= STATUS_OK;
      out_found_q   <= '0;
      out_match_q   <= '0;
      out_removed_q <= '0;
      out_count_q   <= '0;
    end else begin
      if (out_o.ready && !out_load) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            func_q  <= in_i.func;
            value_q <= in_i.value;
            pos_q   <= in_i.position;
            state_q <= ST_CELL;
          end
        end
        ST_CELL: begin
          pre_status_q <= STATUS_OK;
          removed_q    <= entry_w[pos_q[IDX_W-1:0]];
          if (cell_ctrl.upd_ins) begin
            count_q <= count_q + CNT_W'(1);
          end else if (cell_ctrl.upd_rem) begin
            count_q <= count_q - CNT_W'(1);
          end
          if ((func_q == FUNC_INSERT) && full) begin
            pre_status_q <= STATUS_FULL;
          end else if ((func_q == FUNC_REMOVE) && bad_index) begin
            pre_status_q <= STATUS_BAD_INDEX;
          end
          state_q <= ST_GROUP;
        end
        ST_GROUP: begin
          state_q <= ST_FINISH;
        end
        ST_FINISH: begin
          if (out_load) begin
            out_valid_q   <= 1'b1;
            out_status_q  <= res_status;
            out_found_q   <= res_found;
            out_match_q   <= res_match;
            out_removed_q <= res_removed;
            out_count_q   <= count_q;
            state_q       <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.status        = out_status_q;
  assign out_o.found_index   = out_found_q;
  assign out_o.match_count   = out_match_q;
  assign out_o.removed_value = out_removed_q;
  assign out_o.entry_count   = out_count_q;

`ifndef NO_ASSERTIONS
  // The entry count never runs past the capacity.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("entry count exceeds capacity");

  // A committed insert grows the array by exactly one entry.
  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cell_ctrl.upd_ins |=> (count_q == $past(count_q) + CNT_W'(1)))
    else $error("insert did not increment the entry count");

  // A committed removal shrinks the array by exactly one entry.
  a_remove_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cell_ctrl.upd_rem |=> (count_q == $past(count_q) - CNT_W'(1)))
    else $error("remove did not decrement the entry count");

  // A new result beat only appears when the finish step loads it.
  a_out_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_FINISH))
    else $error("result appeared outside the finish step");
`endif

endmodule
